>>> rtl/rpp_pkg.sv
// shared widths, types and register codes for the point rotate and project pipeline
package rpp_pkg;

    localparam int COORD_W = 16;
    localparam int TRIG_W  = 16;
    localparam int FRAC    = 14;
    localparam int AX_W    = 19;
    localparam int BY_W    = 22;
    localparam int DEN_W   = 22;
    localparam int NX_W    = 31;
    localparam int NY_W    = 35;
    localparam int MAG_W   = 35;
    localparam int Q_W     = 18;
    localparam int REM_W   = 23;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_COS_YAW   = 3'd0;
    localparam logic [IDX_W-1:0] REG_SIN_YAW   = 3'd1;
    localparam logic [IDX_W-1:0] REG_COS_PITCH = 3'd2;
    localparam logic [IDX_W-1:0] REG_SIN_PITCH = 3'd3;
    localparam logic [IDX_W-1:0] REG_DISTANCE  = 3'd4;
    localparam logic [IDX_W-1:0] REG_FOCAL     = 3'd5;
    localparam logic [IDX_W-1:0] REG_CENTER_X  = 3'd6;
    localparam logic [IDX_W-1:0] REG_CENTER_Y  = 3'd7;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_yaw;
        logic signed [TRIG_W-1:0] sin_yaw;
        logic signed [TRIG_W-1:0] cos_pitch;
        logic signed [TRIG_W-1:0] sin_pitch;
    } rot_cfg_t;

    typedef struct packed {
        logic signed [AX_W-1:0] bx;
        logic signed [BY_W-1:0] by;
        logic signed [BY_W-1:0] bz;
    } rot_t;

    typedef struct packed {
        logic far;
        logic behind;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } side_t;

    typedef struct packed {
        side_t          side;
        logic [Q_W-1:0] qx;
        logic [Q_W-1:0] qy;
    } quot_t;

endpackage

>>> rtl/rpp_if.sv
// valid/ready channels for input points and screen results
interface point_if;
    logic                              valid;
    logic                              ready;
    logic signed [rpp_pkg::COORD_W-1:0] point_x;
    logic signed [rpp_pkg::COORD_W-1:0] point_y;
    logic signed [rpp_pkg::COORD_W-1:0] point_z;
    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface screen_if;
    logic                              valid;
    logic                              ready;
    logic signed [rpp_pkg::COORD_W-1:0] screen_x;
    logic signed [rpp_pkg::COORD_W-1:0] screen_y;
    logic                              far_side;
    logic                              behind_camera;
    modport source (output valid, screen_x, screen_y, far_side, behind_camera, input ready);
    modport sink (input valid, screen_x, screen_y, far_side, behind_camera, output ready);
endinterface

>>> rtl/rotate_project_point.sv
// top level: configuration registers, rotation, projection and output register
// pipeline: 25 register stages (4 rotate, 2 setup, 18 division steps, 1 output
// register)
// throughput: one point per cycle, set by one quotient bit per divider stage,
// but the whole pipeline holds while the output register is full and not taken
// reset clears valid bits and loads the configuration reset values
module rotate_project_point (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rpp_pkg::IDX_W-1:0]      cfg_index,
    input  logic [rpp_pkg::CFG_W-1:0]      cfg_data,
    point_if.sink                          point,
    screen_if.source                       screen
);
    import rpp_pkg::*;

    rot_cfg_t    rcfg_reg;
    logic [15:0] distance_reg;
    logic [11:0] focal_reg, cx_reg, cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcfg_reg.cos_yaw   <= 16'sd16384;
            rcfg_reg.sin_yaw   <= '0;
            rcfg_reg.cos_pitch <= 16'sd16384;
            rcfg_reg.sin_pitch <= '0;
            distance_reg       <= 16'd25600;
            focal_reg          <= 12'd500;
            cx_reg             <= 12'd600;
            cy_reg             <= 12'd450;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COS_YAW:   rcfg_reg.cos_yaw   <= cfg_data;
                REG_SIN_YAW:   rcfg_reg.sin_yaw   <= cfg_data;
                REG_COS_PITCH: rcfg_reg.cos_pitch <= cfg_data;
                REG_SIN_PITCH: rcfg_reg.sin_pitch <= cfg_data;
                REG_DISTANCE:  distance_reg       <= cfg_data;
                REG_FOCAL:     focal_reg          <= cfg_data[11:0];
                REG_CENTER_X:  cx_reg             <= cfg_data[11:0];
                REG_CENTER_Y:  cy_reg             <= cfg_data[11:0];
                default:       ;
            endcase
        end
    end

    logic   out_valid_reg;
    logic   adv;
    logic   rot_valid, div_valid;
    rot_t   rot;
    quot_t  quot;

    assign adv         = !out_valid_reg || screen.ready;
    assign point.ready = adv;

    rpp_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (point.valid),
        .px        (point.point_x),
        .py        (point.point_y),
        .pz        (point.point_z),
        .cfg       (rcfg_reg),
        .out_valid (rot_valid),
        .out_rot   (rot)
    );

    rpp_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (rot_valid),
        .rot       (rot),
        .distance  (distance_reg),
        .focal     (focal_reg),
        .out_valid (div_valid),
        .out_q     (quot)
    );

    logic signed [19:0]  sx_sum, sy_sum;
    logic signed [15:0]  sx_next, sy_next;
    logic signed [15:0]  sx_reg, sy_reg;
    logic                far_reg, behind_reg;

    function automatic logic signed [15:0] finish(input logic [Q_W-1:0] q, input logic neg,
                                                  input logic ovf, input logic [11:0] c);
        logic signed [19:0] s;
        logic signed [15:0] r;
        s = neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
        s = s + $signed({8'b0, c});
        if (ovf)
            r = neg ? -16'sd32768 : 16'sd32767;
        else if (s > 20'sd32767)
            r = 16'sd32767;
        else if (s < -20'sd32768)
            r = -16'sd32768;
        else
            r = s[15:0];
        return r;
    endfunction

    always_comb
    begin
        sx_sum  = '0;
        sy_sum  = '0;
        sx_next = finish(quot.qx, quot.side.neg_x, quot.side.ovf_x, cx_reg);
        sy_next = finish(quot.qy, quot.side.neg_y, quot.side.ovf_y, cy_reg);
        if (quot.side.behind)
        begin
            sx_next = '0;
            sy_next = '0;
        end
        sx_sum = 20'(sx_next);
        sy_sum = 20'(sy_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg     <= sx_sum[15:0];
            sy_reg     <= sy_sum[15:0];
            far_reg    <= quot.side.far;
            behind_reg <= quot.side.behind;
        end
    end

    assign screen.valid         = out_valid_reg;
    assign screen.screen_x      = sx_reg;
    assign screen.screen_y      = sy_reg;
    assign screen.far_side      = far_reg;
    assign screen.behind_camera = behind_reg;
endmodule

>>> rtl/rpp_rotate.sv
// four stage yaw then pitch rotation of one point
module rpp_rotate (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic signed [rpp_pkg::COORD_W-1:0] px,
    input  logic signed [rpp_pkg::COORD_W-1:0] py,
    input  logic signed [rpp_pkg::COORD_W-1:0] pz,
    input  rpp_pkg::rot_cfg_t                  cfg,
    output logic                               out_valid,
    output rpp_pkg::rot_t                      out_rot
);
    import rpp_pkg::*;

    logic [3:0] v_reg;

    logic signed [31:0]        p_xc_reg, p_zs_reg, p_zc_reg, p_xs_reg;
    logic signed [COORD_W-1:0] py1_reg, py2_reg;
    logic signed [AX_W-1:0]    ax_reg, az_reg, bx3_reg;
    logic signed [31:0]        p_yc_reg, p_ys_reg;
    logic signed [34:0]        p_as_reg, p_ac_reg;
    rot_t                      rot_reg;

    logic signed [32:0] sum_x, sum_z;
    logic signed [35:0] sum_y, sum_bz;

    always_comb
    begin
        sum_x  = 33'(p_xc_reg) + 33'(p_zs_reg);
        sum_z  = 33'(p_zc_reg) - 33'(p_xs_reg);
        sum_y  = 36'(p_yc_reg) - 36'(p_as_reg);
        sum_bz = 36'(p_ys_reg) + 36'(p_ac_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_xc_reg <= px * cfg.cos_yaw;
            p_zs_reg <= pz * cfg.sin_yaw;
            p_zc_reg <= pz * cfg.cos_yaw;
            p_xs_reg <= px * cfg.sin_yaw;
            py1_reg  <= py;
            // arithmetic shift gives the floor
            ax_reg   <= AX_W'(sum_x >>> FRAC);
            az_reg   <= AX_W'(sum_z >>> FRAC);
            py2_reg  <= py1_reg;
            p_yc_reg <= py2_reg * cfg.cos_pitch;
            p_ys_reg <= py2_reg * cfg.sin_pitch;
            p_as_reg <= az_reg * cfg.sin_pitch;
            p_ac_reg <= az_reg * cfg.cos_pitch;
            bx3_reg  <= ax_reg;
            rot_reg.bx <= bx3_reg;
            rot_reg.by <= BY_W'(sum_y >>> FRAC);
            rot_reg.bz <= BY_W'(sum_bz >>> FRAC);
        end
    end

    assign out_valid = v_reg[3];
    assign out_rot   = rot_reg;
endmodule

>>> rtl/rpp_divide.sv
// perspective numerators, denominator and pipelined restoring division for both axes
module rpp_divide (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic                             in_valid,
    input  rpp_pkg::rot_t                    rot,
    input  logic [15:0]                      distance,
    input  logic [11:0]                      focal,
    output logic                             out_valid,
    output rpp_pkg::quot_t                   out_q
);
    import rpp_pkg::*;

    localparam int STAGES = Q_W + 2;

    logic [STAGES-1:0] v_reg;

    // numerator and denominator stage
    logic signed [22:0]   denom_reg;
    logic signed [NX_W-1:0] nx_reg;
    logic signed [NY_W-1:0] ny_reg;
    logic                 far_reg;

    // division stages, index 0 holds the initial remainder
    logic [DEN_W-1:0] den_reg [0:Q_W];
    logic [REM_W-1:0] remx_reg [0:Q_W];
    logic [REM_W-1:0] remy_reg [0:Q_W];
    logic [Q_W-1:0]   lox_reg [0:Q_W];
    logic [Q_W-1:0]   loy_reg [0:Q_W];
    logic [Q_W-1:0]   qx_reg [0:Q_W];
    logic [Q_W-1:0]   qy_reg [0:Q_W];
    side_t            side_reg [0:Q_W];

    logic signed [35:0] nxw, nyw;
    logic [MAG_W-1:0]   magx, magy;
    logic [DEN_W-1:0]   den0;

    always_comb
    begin
        nxw  = 36'(nx_reg);
        nyw  = 36'(ny_reg);
        magx = MAG_W'(nxw[35] ? -nxw : nxw);
        magy = MAG_W'(nyw[35] ? -nyw : nyw);
        den0 = denom_reg[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            denom_reg <= $signed({7'b0, distance}) - 23'(rot.bz);
            far_reg   <= rot.bz > 0;
            nx_reg    <= rot.bx * $signed({1'b0, focal});
            ny_reg    <= rot.by * $signed({1'b0, focal});

            den_reg[0]         <= den0;
            remx_reg[0]        <= REM_W'(magx[MAG_W-1:Q_W]);
            remy_reg[0]        <= REM_W'(magy[MAG_W-1:Q_W]);
            lox_reg[0]         <= magx[Q_W-1:0];
            loy_reg[0]         <= magy[Q_W-1:0];
            qx_reg[0]          <= '0;
            qy_reg[0]          <= '0;
            side_reg[0].far    <= far_reg;
            side_reg[0].behind <= denom_reg <= 0;
            side_reg[0].neg_x  <= nxw[35];
            side_reg[0].neg_y  <= nyw[35];
            // quotient too large for the pipeline means the result saturates
            side_reg[0].ovf_x  <= {5'b0, magx} >= {den0, Q_W'(0)};
            side_reg[0].ovf_y  <= {5'b0, magy} >= {den0, Q_W'(0)};
        end
    end

    genvar k;
    generate
        for (k = 1; k <= Q_W; k++)
        begin : g_step
            logic [REM_W:0] tx, ty;
            logic           bitx, bity;
            always_comb
            begin
                tx   = {remx_reg[k-1], lox_reg[k-1][Q_W-1]};
                ty   = {remy_reg[k-1], loy_reg[k-1][Q_W-1]};
                bitx = tx >= (REM_W+1)'(den_reg[k-1]);
                bity = ty >= (REM_W+1)'(den_reg[k-1]);
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    den_reg[k]  <= den_reg[k-1];
                    remx_reg[k] <= REM_W'(bitx ? tx - (REM_W+1)'(den_reg[k-1]) : tx);
                    remy_reg[k] <= REM_W'(bity ? ty - (REM_W+1)'(den_reg[k-1]) : ty);
                    lox_reg[k]  <= {lox_reg[k-1][Q_W-2:0], 1'b0};
                    loy_reg[k]  <= {loy_reg[k-1][Q_W-2:0], 1'b0};
                    qx_reg[k]   <= {qx_reg[k-1][Q_W-2:0], bitx};
                    qy_reg[k]   <= {qy_reg[k-1][Q_W-2:0], bity};
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    endgenerate

    assign out_valid  = v_reg[STAGES-1];
    assign out_q.side = side_reg[Q_W];
    assign out_q.qx   = qx_reg[Q_W];
    assign out_q.qy   = qy_reg[Q_W];
endmodule
